FILE: design/mbrm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU read master package
// Shared codes, constants and the CRC-16 byte update for the read master.
// ----------------------------------------------------------------------------
package mbrm_pkg;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_WINDOW = 2'd2
  } in_kind_e;

  typedef enum logic [1:0] {
    OUT_TX     = 2'd0,
    OUT_ACCEPT = 2'd1,
    OUT_REJECT = 2'd2
  } out_kind_e;

  typedef enum logic [1:0] {
    CFG_DEVICE_ADDRESS = 2'd0,
    CFG_FUNCTION_CODE  = 2'd1,
    CFG_REGISTER_A     = 2'd2,
    CFG_REGISTER_B     = 2'd3
  } cfg_index_e;

  localparam logic [1:0] REQ_A_ONE = 2'd0;
  localparam logic [1:0] REQ_B_ONE = 2'd1;
  localparam logic [1:0] REQ_A_TWO = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [3:0] LEN_SHORT = 4'd7;
  localparam logic [3:0] LEN_LONG  = 4'd9;
  localparam logic [3:0] DATA_FIRST_POS = 4'd3;

  localparam logic [7:0]  DEVICE_ADDRESS_RST = 8'h01;
  localparam logic [7:0]  FUNCTION_CODE_RST  = 8'h04;
  localparam logic [15:0] REGISTER_A_RST     = 16'h0001;
  localparam logic [15:0] REGISTER_B_RST     = 16'h0002;

  function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: design/modbus_rtu_read_master_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU read master
// Each result is registered in the output register when its transaction is
// taken; bytes and window ends are taken one per cycle while the output is
// free. A start holds the input off until its request bytes have left, one per
// cycle while the output is free, the request CRC folded a byte at a time.
// Reset is asynchronous, active low, and restores the register defaults.
// ----------------------------------------------------------------------------
module modbus_rtu_read_master_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [1:0]  request_select_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       out_kind_o,
  output logic [7:0]       tx_byte_o,
  output logic             tx_last_o,
  output logic [15:0]      first_value_o,
  output logic [15:0]      second_value_o,
  output logic             two_values_o
);
  import mbrm_pkg::*;

  logic [7:0]  dev_addr_q, func_code_q;
  logic [15:0] reg_a_q, reg_b_q;

  logic [1:0]  sel_q, sel_d;
  logic        await_q, await_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] rx_crc_q, rx_crc_d;
  logic [31:0] data_q, data_d;
  logic [15:0] tail_q, tail_d;

  logic        burst_q, burst_d;
  logic [2:0]  idx_q, idx_d;
  logic [4:0][7:0] frame_q, frame_d;
  logic [15:0] tx_crc_q, tx_crc_d;

  logic        out_valid_q, out_valid_d;
  logic        load_out;
  logic [1:0]  out_kind_q, out_kind_d;
  logic [7:0]  tx_byte_q, tx_byte_d;
  logic        tx_last_q, tx_last_d;
  logic [15:0] first_q, first_d;
  logic [15:0] second_q, second_d;
  logic        two_q, two_d;

  logic        out_free, in_fire, cfg_fire;
  logic [3:0]  len;
  logic [15:0] req_reg;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = !burst_q && out_free;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign len         = (sel_q == REQ_A_TWO) ? LEN_LONG : LEN_SHORT;
  assign req_reg     = (request_select_i == REQ_B_ONE) ? reg_b_q : reg_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= DEVICE_ADDRESS_RST;
      func_code_q <= FUNCTION_CODE_RST;
      reg_a_q     <= REGISTER_A_RST;
      reg_b_q     <= REGISTER_B_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_DEVICE_ADDRESS: dev_addr_q  <= cfg_data_i[7:0];
        CFG_FUNCTION_CODE:  func_code_q <= cfg_data_i[7:0];
        CFG_REGISTER_A:     reg_a_q     <= cfg_data_i;
        CFG_REGISTER_B:     reg_b_q     <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    sel_d       = sel_q;
    await_d     = await_q;
    cnt_d       = cnt_q;
    rx_crc_d    = rx_crc_q;
    data_d      = data_q;
    tail_d      = tail_q;
    burst_d     = burst_q;
    idx_d       = idx_q;
    frame_d     = frame_q;
    tx_crc_d    = tx_crc_q;
    load_out    = 1'b0;
    out_kind_d  = out_kind_q;
    tx_byte_d   = tx_byte_q;
    tx_last_d   = tx_last_q;
    first_d     = first_q;
    second_d    = second_q;
    two_d       = two_q;

    if (burst_q && out_free) begin
      load_out   = 1'b1;
      out_kind_d = OUT_TX;
      tx_last_d  = (idx_q == 3'd7);
      first_d    = 16'h0000;
      second_d   = 16'h0000;
      two_d      = 1'b0;
      idx_d      = idx_q + 3'd1;
      case (idx_q)
        3'd6: tx_byte_d = tx_crc_q[7:0];
        3'd7: begin
          tx_byte_d = tx_crc_q[15:8];
          burst_d   = 1'b0;
        end
        default: begin
          tx_byte_d = frame_q[0];
          tx_crc_d  = crc_fold(tx_crc_q, frame_q[0]);
          frame_d   = {8'h00, frame_q[4:1]};
        end
      endcase
    end

    if (in_fire) begin
      case (kind_i)
        KIND_START: begin
          if (request_select_i != REQ_NONE) begin
            load_out   = 1'b1;
            out_kind_d = OUT_TX;
            tx_byte_d  = dev_addr_q;
            tx_last_d  = 1'b0;
            first_d    = 16'h0000;
            second_d   = 16'h0000;
            two_d      = 1'b0;
            tx_crc_d   = crc_fold(CRC_INIT, dev_addr_q);
            frame_d    = {((request_select_i == REQ_A_TWO) ? 8'd2 : 8'd1), 8'h00,
                          req_reg[7:0], req_reg[15:8], func_code_q};
            burst_d    = 1'b1;
            idx_d      = 3'd1;
            sel_d      = request_select_i;
            await_d    = 1'b1;
            cnt_d      = 4'd0;
            rx_crc_d   = CRC_INIT;
            data_d     = 32'h0000_0000;
            tail_d     = 16'h0000;
          end
        end
        KIND_BYTE: begin
          if (await_q && (cnt_q < len)) begin
            if (cnt_q < (len - 4'd2)) begin
              rx_crc_d = crc_fold(rx_crc_q, rx_byte_i);
              case (cnt_q)
                DATA_FIRST_POS:         data_d[31:24] = rx_byte_i;
                DATA_FIRST_POS + 4'd1:  data_d[23:16] = rx_byte_i;
                DATA_FIRST_POS + 4'd2:  data_d[15:8]  = rx_byte_i;
                DATA_FIRST_POS + 4'd3:  data_d[7:0]   = rx_byte_i;
                default: ;
              endcase
            end else if (cnt_q == (len - 4'd2)) begin
              tail_d[7:0] = rx_byte_i;
            end else begin
              tail_d[15:8] = rx_byte_i;
            end
            cnt_d = cnt_q + 4'd1;
          end
        end
        KIND_WINDOW: begin
          if (await_q) begin
            await_d   = 1'b0;
            load_out  = 1'b1;
            tx_byte_d = 8'h00;
            tx_last_d = 1'b0;
            if ((cnt_q == len) && (tail_q == rx_crc_q)) begin
              out_kind_d = OUT_ACCEPT;
              first_d    = data_q[31:16];
              second_d   = (sel_q == REQ_A_TWO) ? data_q[15:0] : 16'h0000;
              two_d      = (sel_q == REQ_A_TWO);
            end else begin
              out_kind_d = OUT_REJECT;
              first_d    = 16'h0000;
              second_d   = 16'h0000;
              two_d      = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= REQ_A_ONE;
      await_q     <= 1'b0;
      cnt_q       <= 4'd0;
      rx_crc_q    <= CRC_INIT;
      data_q      <= 32'h0000_0000;
      tail_q      <= 16'h0000;
      burst_q     <= 1'b0;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      sel_q       <= sel_d;
      await_q     <= await_d;
      cnt_q       <= cnt_d;
      rx_crc_q    <= rx_crc_d;
      data_q      <= data_d;
      tail_q      <= tail_d;
      burst_q     <= burst_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q    <= frame_d;
    tx_crc_q   <= tx_crc_d;
    out_kind_q <= out_kind_d;
    tx_byte_q  <= tx_byte_d;
    tx_last_q  <= tx_last_d;
    first_q    <= first_d;
    second_q   <= second_d;
    two_q      <= two_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = out_kind_q;
  assign tx_byte_o      = tx_byte_q;
  assign tx_last_o      = tx_last_q;
  assign first_value_o  = first_q;
  assign second_value_o = second_q;
  assign two_values_o   = two_q;

endmodule
`default_nettype wire

FILE: tb/sv/modbus_rtu_read_master_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU read master testbench
// Drives start, received-byte and window-end transactions into the read master
// and writes its four registers between phases. A behavioral model of the
// request framing, the CRC-16 and the response checks predicts every result.
// Each result is compared field by field with the oldest prediction. Both
// sides idle and stall at random, and one phase holds the output side off long
// enough to fill the block.
// ----------------------------------------------------------------------------
module modbus_rtu_read_master_unit_test;
  import mbrm_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    out_kind_e   kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [15:0] first_value;
    logic [15:0] second_value;
    logic        two_values;
  } reading_t;

  typedef enum int {RESP_GOOD, RESP_BAD_CRC, RESP_SHORT, RESP_LONG} resp_shape_e;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        cfg_valid_i      = 1'b0;
  logic [1:0]  cfg_index_i      = CFG_DEVICE_ADDRESS;
  logic [15:0] cfg_data_i       = '0;
  logic        in_valid_i       = 1'b0;
  logic [1:0]  kind_i           = KIND_START;
  logic [1:0]  request_select_i = REQ_A_ONE;
  logic [7:0]  rx_byte_i        = '0;
  logic        out_ready_i      = 1'b0;
  wire logic        cfg_ready_o;
  wire logic        in_ready_o;
  wire logic        out_valid_o;
  wire logic [1:0]  out_kind_o;
  wire logic [7:0]  tx_byte_o;
  wire logic        tx_last_o;
  wire logic [15:0] first_value_o;
  wire logic [15:0] second_value_o;
  wire logic        two_values_o;

  // Model copy of the registers and of the exchange in progress.
  logic [7:0]  dev_addr  = DEVICE_ADDRESS_RST;
  logic [7:0]  func_code = FUNCTION_CODE_RST;
  logic [15:0] reg_a     = REGISTER_A_RST;
  logic [15:0] reg_b     = REGISTER_B_RST;
  logic [1:0]  pend_sel     = REQ_A_ONE;
  logic        pend_waiting = 1'b0;
  logic [3:0]  pend_count   = '0;
  logic [15:0] pend_crc     = CRC_INIT;
  logic [31:0] pend_data    = '0;
  logic [15:0] pend_tail    = '0;

  reading_t expected_readings[$];
  int error_count     = 0;
  int effective_items = 0;
  int hold_request    = 0;
  int stall_left      = 0;
  int ready_gap       = 0;
  bit offering        = 1'b0;
  bit burst_mode      = 1'b0;

  modbus_rtu_read_master_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .request_select_i (request_select_i),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_kind_o       (out_kind_o),
    .tx_byte_o        (tx_byte_o),
    .tx_last_o        (tx_last_o),
    .first_value_o    (first_value_o),
    .second_value_o   (second_value_o),
    .two_values_o     (two_values_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] acc;
    logic        lsb;
    acc = crc ^ {8'h00, b};
    repeat (8) begin
      lsb = acc[0];
      acc = acc >> 1;
      if (lsb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  function automatic logic [3:0] response_length(logic [1:0] sel);
    return (sel == REQ_A_TWO) ? LEN_LONG : LEN_SHORT;
  endfunction

  function automatic void push_reading(out_kind_e k, logic [7:0] tx, logic last,
                                       logic [15:0] v1, logic [15:0] v2, logic two);
    reading_t r;
    r.kind         = k;
    r.tx_byte      = tx;
    r.tx_last      = last;
    r.first_value  = v1;
    r.second_value = v2;
    r.two_values   = two;
    expected_readings.push_back(r);
  endfunction

  // Returns 1 when the transaction changes state or causes a result.
  function automatic bit predict_item(logic [1:0] kind, logic [1:0] sel, logic [7:0] rx);
    logic [7:0]  frame [8];
    logic [15:0] reg_val;
    logic [15:0] crc;
    logic [3:0]  len;
    logic        two;
    int          shift;
    case (kind)
      KIND_START: begin
        if (sel == REQ_NONE) begin
          return 1'b0;
        end
        reg_val  = (sel == REQ_B_ONE) ? reg_b : reg_a;
        frame[0] = dev_addr;
        frame[1] = func_code;
        frame[2] = reg_val[15:8];
        frame[3] = reg_val[7:0];
        frame[4] = 8'h00;
        frame[5] = (sel == REQ_A_TWO) ? 8'd2 : 8'd1;
        crc = CRC_INIT;
        for (int i = 0; i < 6; i++) begin
          crc = crc16_update(crc, frame[i]);
        end
        frame[6] = crc[7:0];
        frame[7] = crc[15:8];
        for (int i = 0; i < 8; i++) begin
          push_reading(OUT_TX, frame[i], i == 7, '0, '0, 1'b0);
        end
        pend_sel     = sel;
        pend_waiting = 1'b1;
        pend_count   = '0;
        pend_crc     = CRC_INIT;
        pend_data    = '0;
        pend_tail    = '0;
        return 1'b1;
      end
      KIND_BYTE: begin
        if (!pend_waiting) begin
          return 1'b0;
        end
        len = response_length(pend_sel);
        if (pend_count >= len) begin
          return 1'b0;
        end
        if (pend_count < len - 4'd2) begin
          pend_crc = crc16_update(pend_crc, rx);
          if (pend_count >= DATA_FIRST_POS) begin
            shift = 8 * (6 - int'(pend_count));
            pend_data = pend_data | ({24'h0, rx} << shift);
          end
        end else if (pend_count == len - 4'd2) begin
          pend_tail[7:0] = rx;
        end else begin
          pend_tail[15:8] = rx;
        end
        pend_count = pend_count + 4'd1;
        return 1'b1;
      end
      KIND_WINDOW: begin
        if (!pend_waiting) begin
          return 1'b0;
        end
        pend_waiting = 1'b0;
        len = response_length(pend_sel);
        if (pend_count == len && pend_tail == pend_crc) begin
          two = (pend_sel == REQ_A_TWO);
          push_reading(OUT_ACCEPT, '0, 1'b0, pend_data[31:16],
                       two ? pend_data[15:0] : 16'h0000, two);
        end else begin
          push_reading(OUT_REJECT, '0, 1'b0, '0, '0, 1'b0);
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= 100) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  task automatic check_reading();
    reading_t exp;
    if (expected_readings.size() == 0) begin
      report_mismatch($sformatf("unexpected result, out_kind %0d", out_kind_o));
      return;
    end
    exp = expected_readings.pop_front();
    if (out_kind_o !== exp.kind) begin
      report_mismatch($sformatf("out_kind %0d, expected %0d", out_kind_o, exp.kind));
    end
    if (tx_byte_o !== exp.tx_byte) begin
      report_mismatch($sformatf("tx_byte %h, expected %h", tx_byte_o, exp.tx_byte));
    end
    if (tx_last_o !== exp.tx_last) begin
      report_mismatch($sformatf("tx_last %b, expected %b", tx_last_o, exp.tx_last));
    end
    if (first_value_o !== exp.first_value) begin
      report_mismatch($sformatf("first_value %h, expected %h",
                                first_value_o, exp.first_value));
    end
    if (second_value_o !== exp.second_value) begin
      report_mismatch($sformatf("second_value %h, expected %h",
                                second_value_o, exp.second_value));
    end
    if (two_values_o !== exp.two_values) begin
      report_mismatch($sformatf("two_values %b, expected %b",
                                two_values_o, exp.two_values));
    end
  endtask

  // Output side: checks each accepted transaction and decides the next ready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        check_reading();
      end
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (burst_mode) begin
        out_ready_i <= 1'b1;
      end else begin
        ready_gap = pick_gap();
        if (ready_gap > 0) begin
          out_ready_i <= 1'b0;
          stall_left = ready_gap - 1;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  task automatic send_item(logic [1:0] kind, logic [1:0] sel, logic [7:0] rx);
    int gap;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      if (offering) begin
        in_valid_i <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    kind_i           <= kind;
    request_select_i <= sel;
    rx_byte_i        <= rx;
    offering = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (predict_item(kind, sel, rx)) begin
      effective_items++;
    end
  endtask

  task automatic release_input();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic wait_drained();
    release_input();
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic apply_config(logic [15:0] addr_v, logic [15:0] func_v,
                              logic [15:0] ra_v, logic [15:0] rb_v);
    logic [15:0] vals [4];
    vals = '{addr_v, func_v, ra_v, rb_v};
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_index_e'(i);
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (cfg_index_e'(i))
        CFG_DEVICE_ADDRESS: dev_addr  = vals[i][7:0];
        CFG_FUNCTION_CODE:  func_code = vals[i][7:0];
        CFG_REGISTER_A:     reg_a     = vals[i];
        CFG_REGISTER_B:     reg_b     = vals[i];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic start_request(logic [1:0] sel);
    send_item(KIND_START, sel, 8'($urandom()));
  endtask

  // Sends a response for the request in progress, then closes the window.
  task automatic send_response(resp_shape_e shape, bit random_data, logic [31:0] data);
    logic [7:0]  frame [$];
    logic [15:0] crc;
    logic [3:0]  len;
    int          idx;
    len = response_length(pend_sel);
    if (random_data) begin
      data = $urandom();
    end
    frame.push_back($urandom_range(0, 1) ? dev_addr : 8'($urandom()));
    frame.push_back($urandom_range(0, 1) ? func_code : 8'($urandom()));
    frame.push_back((len == LEN_LONG) ? 8'd4 : 8'd2);
    frame.push_back(data[31:24]);
    frame.push_back(data[23:16]);
    if (len == LEN_LONG) begin
      frame.push_back(data[15:8]);
      frame.push_back(data[7:0]);
    end
    crc = CRC_INIT;
    foreach (frame[i]) begin
      crc = crc16_update(crc, frame[i]);
    end
    frame.push_back(crc[7:0]);
    frame.push_back(crc[15:8]);
    case (shape)
      RESP_BAD_CRC: begin
        idx = $urandom_range(0, frame.size() - 1);
        frame[idx] = frame[idx] ^ (8'h01 << $urandom_range(0, 7));
      end
      RESP_SHORT: begin
        repeat ($urandom_range(1, len)) void'(frame.pop_back());
      end
      RESP_LONG: begin
        repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom()));
      end
      default: ;
    endcase
    foreach (frame[i]) begin
      send_item(KIND_BYTE, 2'($urandom()), frame[i]);
    end
    send_item(KIND_WINDOW, 2'($urandom()), 8'($urandom()));
  endtask

  task automatic run_exchange(resp_shape_e shape);
    start_request(2'($urandom_range(0, 2)));
    send_response(shape, 1'b1, '0);
  endtask

  task automatic test_directed_cases();
    send_item(KIND_BYTE, REQ_NONE, 8'hFF);
    send_item(KIND_WINDOW, REQ_A_TWO, 8'h00);
    send_item(KIND_UNUSED, REQ_B_ONE, 8'hA5);
    send_item(KIND_START, REQ_NONE, 8'h5A);
    start_request(REQ_A_ONE);
    send_response(RESP_GOOD, 1'b0, 32'h0000_0000);
    // A second start while waiting restarts the exchange.
    start_request(REQ_B_ONE);
    start_request(REQ_A_TWO);
    send_response(RESP_LONG, 1'b0, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  task automatic test_config_extremes();
    for (int setting = 0; setting < 4; setting++) begin
      case (setting)
        0: apply_config(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        1: apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: apply_config({8'h00, DEVICE_ADDRESS_RST}, {8'h00, FUNCTION_CODE_RST},
                        REGISTER_A_RST, REGISTER_B_RST);
        default: apply_config(16'($urandom()), 16'($urandom()),
                              16'($urandom()), 16'($urandom()));
      endcase
      for (int s = 0; s < 3; s++) begin
        start_request(2'(s));
        send_response(RESP_GOOD, 1'b1, '0);
      end
    end
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    wait_drained();
    hold_request = 400;
    burst_mode   = 1'b1;
    repeat (4) run_exchange(RESP_GOOD);
    burst_mode = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int target;
    int r;
    target = effective_items + 40;
    while (effective_items < target) begin
      burst_mode = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 3) begin
        apply_config(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
      end else if (r < 8) begin
        wait_drained();
      end else if (r < 60) begin
        run_exchange(RESP_GOOD);
      end else if (r < 70) begin
        run_exchange(RESP_BAD_CRC);
      end else if (r < 78) begin
        run_exchange(RESP_SHORT);
      end else if (r < 85) begin
        run_exchange(RESP_LONG);
      end else if (r < 91) begin
        start_request(2'($urandom_range(0, 2)));
        start_request(2'($urandom_range(0, 2)));
        send_response(RESP_GOOD, 1'b1, '0);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_item(2'($urandom()), 2'($urandom()), 8'($urandom()));
        end
      end
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_config_extremes();
    test_output_backpressure();
    test_random_traffic();
    release_input();
    for (int n = 0; n < 20000 && expected_readings.size() != 0; n++) begin
      @(posedge clk_i);
    end
    repeat (16) @(posedge clk_i);
    if (expected_readings.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_readings.size()));
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout at %0t", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
design/mbrm_pkg.sv
design/modbus_rtu_read_master_unit.sv
tb/sv/modbus_rtu_read_master_unit_test.sv
